/* src/smpf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectrum magnitude peak finder package
// Shared widths, constants and reset values of the peak finder.
// ----------------------------------------------------------------------------
package smpf_pkg;

    localparam int RE_W       = 16;
    localparam int MAG_W      = 17;
    localparam int IDX_W      = 9;
    localparam int FREQ_W     = 20;
    localparam int RATE_W     = 20;

    // Square root unit: radicand is 4*(re^2+im^2), one root bit per step.
    localparam int RAD_W      = 34;
    localparam int ROOT_W     = 17;
    localparam int REM_W      = ROOT_W + 4;
    localparam int STEP_W     = $clog2(ROOT_W);

    // Shared multiplier operands and product.
    localparam int MUL_A_W    = 16;
    localparam int MUL_B_W    = 20;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int POWER_W    = 32;

    // The transform length must be a power of two.
    localparam int FFT_LENGTH = 1024;
    localparam int FFT_SHIFT  = $clog2(FFT_LENGTH);

    localparam int DEF_BIN_COUNT = 512;

    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(10000);
    localparam logic [FREQ_W-1:0] FREQ_MAX   = FREQ_W'(1000000);

endpackage

/* src/smpf_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peak finder channels
// Valid/ready channels for input bins and result beats.
// ----------------------------------------------------------------------------
interface smpf_in_if;
    import smpf_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [RE_W-1:0]  real_part;
    logic signed [RE_W-1:0]  imag_part;
    logic                    last_bin;

    modport source (output valid, real_part, imag_part, last_bin, input ready);
    modport sink   (input valid, real_part, imag_part, last_bin, output ready);
endinterface

interface smpf_out_if;
    import smpf_pkg::*;

    logic               valid;
    logic               ready;
    logic [MAG_W-1:0]   magnitude;
    logic [IDX_W-1:0]   bin_index;
    logic               frame_done;
    logic [IDX_W-1:0]   peak_bin;
    logic [MAG_W-1:0]   peak_magnitude;
    logic [FREQ_W-1:0]  peak_frequency;

    modport source (output valid, magnitude, bin_index, frame_done, peak_bin,
                    peak_magnitude, peak_frequency, input ready);
    modport sink   (input valid, magnitude, bin_index, frame_done, peak_bin,
                    peak_magnitude, peak_frequency, output ready);
endinterface

/* src/smpf_isqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative integer square root
// Digit-by-digit root: one compare and subtract per cycle, one root bit each.
// ----------------------------------------------------------------------------
module smpf_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [smpf_pkg::RAD_W-1:0]    i_radicand,
    output logic                          o_busy,
    output logic                          o_done,
    output logic [smpf_pkg::ROOT_W-1:0]   o_root
);
    import smpf_pkg::*;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ROOT_W - 1);

    logic [RAD_W-1:0]  r_x,    n_x;
    logic [REM_W-1:0]  r_rem,  n_rem;
    logic [ROOT_W-1:0] r_root, n_root;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_busy, n_busy;
    logic              r_done, n_done;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;

    always_comb begin
        rem_sh = {r_rem[REM_W-3:0], r_x[RAD_W-1 -: 2]};
        trial  = REM_W'({r_root, 2'b01});

        n_x    = r_x;
        n_rem  = r_rem;
        n_root = r_root;
        n_step = r_step;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_x    = i_radicand;
            n_rem  = '0;
            n_root = '0;
            n_step = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_x = {r_x[RAD_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                n_rem  = rem_sh - trial;
                n_root = {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                n_rem  = rem_sh;
                n_root = {r_root[ROOT_W-2:0], 1'b0};
            end
            n_step = r_step + STEP_W'(1);
            if (r_step == LAST_STEP) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
        r_x    <= n_x;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_root = r_root;

endmodule

/* src/spectrum_magnitude_peak_finder_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spectrum magnitude peak finder
// Per-bin magnitude floor(2*sqrt(re^2+im^2)) with running peak and frequency.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one FFT bin per beat (real, imaginary, last flag), bins in
//   order from bin 0. o_out returns one beat per bin: magnitude and index,
//   and on the last bin also the peak bin, its magnitude and its frequency
//   peak_bin*sample_rate*2/FFT_LENGTH, saturated at 1000000.
//   i_cfg_we/i_cfg_wdata write the sample rate; write it only while idle.
// Sequence:
//   An accepted bin passes S_SQ_RE, S_SQ_IM (the shared 16x20 multiplier
//   squares each part), S_SUM, S_ROOT (the square root, one root bit per
//   cycle) and, on the last bin only, S_FREQ (frequency product) before
//   S_OUT loads the output register and the next bin can be accepted;
//   i_in.ready is high only while the sequencer is idle.
// Reset and stall:
//   Reset clears the frame (counter 0, peak bin 1, peak magnitude 0) and
//   sets the sample rate to 10000. A finished result waits in the output
//   register; the next bin is accepted meanwhile, and the sequencer holds
//   its own result until the receiver takes the previous beat.
// ----------------------------------------------------------------------------
module spectrum_magnitude_peak_finder_top #(
    parameter int BIN_COUNT = smpf_pkg::DEF_BIN_COUNT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [smpf_pkg::RATE_W-1:0]   i_cfg_wdata,
    smpf_in_if.sink                       i_in,
    smpf_out_if.source                    o_out
);
    import smpf_pkg::*;

    localparam int CNT_W = $clog2(BIN_COUNT);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SQ_RE = 7'b0000010,
        S_SQ_IM = 7'b0000100,
        S_SUM   = 7'b0001000,
        S_ROOT  = 7'b0010000,
        S_FREQ  = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state             r_state, n_state;
    logic [RATE_W-1:0]  r_rate;
    logic [MUL_A_W-1:0] r_abs_re, r_abs_im;
    logic               r_last;
    logic [PROD_W-1:0]  r_prod;
    logic [POWER_W-1:0] r_acc;
    logic [MAG_W-1:0]   r_mag;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   r_best_bin;
    logic [MAG_W-1:0]   r_best_mag;

    logic               r_out_valid;
    logic [MAG_W-1:0]   r_out_mag;
    logic [IDX_W-1:0]   r_out_idx;
    logic               r_out_done;
    logic [IDX_W-1:0]   r_out_pbin;
    logic [MAG_W-1:0]   r_out_pmag;
    logic [FREQ_W-1:0]  r_out_freq;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  prod;
    logic [POWER_W-1:0] power;
    logic               sqrt_start, sqrt_busy, sqrt_done;
    logic [ROOT_W-1:0]  sqrt_root;
    logic [PROD_W-1:0]  freq_full;
    logic [FREQ_W-1:0]  freq_sat;
    logic               in_take, out_take, out_load;
    logic [CNT_W:0]     cnt_inc;

    smpf_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand ({power, 2'b00}),
        .o_busy     (sqrt_busy),
        .o_done     (sqrt_done),
        .o_root     (sqrt_root)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign in_take    = i_in.valid && i_in.ready;
    assign out_take   = r_out_valid && o_out.ready;
    assign out_load   = (r_state == S_OUT) && (!r_out_valid || o_out.ready);
    assign power      = r_acc + r_prod[POWER_W-1:0];
    assign sqrt_start = (r_state == S_SUM);
    assign cnt_inc    = {1'b0, r_cnt} + (CNT_W+1)'(1);

    // The shared multiplier: squares of the parts, then the frequency product.
    always_comb begin
        unique case (r_state)
            S_SQ_RE: begin
                mul_a = r_abs_re;
                mul_b = MUL_B_W'(r_abs_re);
            end
            S_SQ_IM: begin
                mul_a = r_abs_im;
                mul_b = MUL_B_W'(r_abs_im);
            end
            default: begin
                mul_a = MUL_A_W'(r_best_bin);
                mul_b = r_rate;
            end
        endcase
        prod = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // Multiplying by two and dividing by the length is one right shift.
    assign freq_full = r_prod >> (FFT_SHIFT - 1);
    assign freq_sat  = (freq_full > PROD_W'(FREQ_MAX)) ? FREQ_MAX : FREQ_W'(freq_full);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_take) n_state = S_SQ_RE;
            S_SQ_RE: n_state = S_SQ_IM;
            S_SQ_IM: n_state = S_SUM;
            S_SUM:   n_state = S_ROOT;
            S_ROOT:  if (sqrt_done) n_state = r_last ? S_FREQ : S_OUT;
            S_FREQ:  n_state = S_OUT;
            S_OUT:   if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rate      <= RATE_RESET;
            r_cnt       <= '0;
            r_best_bin  <= CNT_W'(1);
            r_best_mag  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_rate <= i_cfg_wdata;
            end
            // Bin 1 always seeds the peak; later bins must be strictly larger.
            if (sqrt_done && (r_state == S_ROOT)) begin
                if (r_cnt == CNT_W'(1)) begin
                    r_best_mag <= sqrt_root;
                    r_best_bin <= CNT_W'(1);
                end else if ((r_cnt > CNT_W'(1)) && (sqrt_root > r_best_mag)) begin
                    r_best_mag <= sqrt_root;
                    r_best_bin <= r_cnt;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
                if (r_last) begin
                    r_cnt      <= '0;
                    r_best_bin <= CNT_W'(1);
                    r_best_mag <= '0;
                end else if (cnt_inc < (CNT_W+1)'(BIN_COUNT)) begin
                    r_cnt <= cnt_inc[CNT_W-1:0];
                end
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end

        if (in_take) begin
            r_abs_re <= i_in.real_part[RE_W-1] ? MUL_A_W'(-i_in.real_part)
                                               : MUL_A_W'(i_in.real_part);
            r_abs_im <= i_in.imag_part[RE_W-1] ? MUL_A_W'(-i_in.imag_part)
                                               : MUL_A_W'(i_in.imag_part);
            r_last   <= i_in.last_bin;
        end
        if ((r_state == S_SQ_RE) || (r_state == S_SQ_IM) || (r_state == S_FREQ)) begin
            r_prod <= prod;
        end
        if (r_state == S_SQ_IM) begin
            r_acc <= r_prod[POWER_W-1:0];
        end
        if (sqrt_done && (r_state == S_ROOT)) begin
            r_mag <= sqrt_root;
        end
        if (out_load) begin
            r_out_mag  <= r_mag;
            r_out_idx  <= IDX_W'(r_cnt);
            r_out_done <= r_last;
            r_out_pbin <= r_last ? IDX_W'(r_best_bin) : '0;
            r_out_pmag <= r_last ? r_best_mag : '0;
            r_out_freq <= r_last ? freq_sat : '0;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.magnitude      = r_out_mag;
    assign o_out.bin_index      = r_out_idx;
    assign o_out.frame_done     = r_out_done;
    assign o_out.peak_bin       = r_out_pbin;
    assign o_out.peak_magnitude = r_out_pmag;
    assign o_out.peak_frequency = r_out_freq;

`ifndef NO_ASSERTIONS
    a_root_only_in_root_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sqrt_done |-> (r_state == S_ROOT))
        else $error("square root finished outside the root state");

    a_idle_unit_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !sqrt_busy)
        else $error("square root unit busy while the sequencer is idle");

    a_frame_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_last) |=> ((r_cnt == '0) && (r_best_bin == CNT_W'(1))
                                  && (r_best_mag == '0)))
        else $error("frame state not cleared after the last bin");

    a_peak_zero_mid_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_done) |-> ((r_out_pbin == '0) && (r_out_pmag == '0)
                                          && (r_out_freq == '0)))
        else $error("peak fields set on a beat that does not end a frame");
`endif

endmodule
